>>> src/csvt_pkg.sv
`default_nettype none
package csvt_pkg;

  // command codes on the input channel
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // token kinds on the result channel
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_FIELD  = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;

  // special characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // parser state bits
  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic skip_linefeed;
    logic field_begun;
    logic field_has_chars;
    logic record_has_fields;
  } csvt_state_t;

  // one token toward the result register
  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [7:0] ch;
  } csvt_tok_t;

endpackage
`default_nettype wire

>>> src/csvt_parse.sv
`default_nettype none
module csvt_parse (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_vld,
  input  wire logic              item_cmd,
  input  wire logic [7:0]        item_byte,
  input  wire logic              advance,
  output csvt_pkg::csvt_tok_t    tok
);

  csvt_pkg::csvt_state_t st_r;
  csvt_pkg::csvt_state_t st_nxt;
  logic                  rec_open;
  logic                  outside;

  // next state and token for the item held in the input register
  always_comb begin
    st_nxt   = st_r;
    tok      = '0;
    outside  = 1'b0;
    rec_open = st_r.record_has_fields | st_r.field_has_chars | st_r.field_begun;
    if (item_cmd == csvt_pkg::CMD_END) begin
      // end of text flushes an open record and returns to reset state
      st_nxt = '0;
      if (rec_open) begin
        tok.vld  = 1'b1;
        tok.kind = csvt_pkg::KIND_RECORD;
      end
    end else if (st_r.skip_linefeed && item_byte == csvt_pkg::CH_LF) begin
      // lf right after cr is dropped
      st_nxt.skip_linefeed = 1'b0;
    end else begin
      st_nxt.skip_linefeed = 1'b0;
      if (st_r.quote_pending) begin
        st_nxt.quote_pending = 1'b0;
        if (item_byte == csvt_pkg::CH_QUOTE) begin
          // doubled quote is one literal quote
          st_nxt.field_has_chars = 1'b1;
          tok.vld  = 1'b1;
          tok.kind = csvt_pkg::KIND_CHAR;
          tok.ch   = csvt_pkg::CH_QUOTE;
        end else begin
          st_nxt.inside_quotes = 1'b0;
          outside = 1'b1;
        end
      end else if (st_r.inside_quotes) begin
        if (item_byte == csvt_pkg::CH_QUOTE) begin
          st_nxt.quote_pending = 1'b1;
        end else begin
          st_nxt.field_has_chars = 1'b1;
          tok.vld  = 1'b1;
          tok.kind = csvt_pkg::KIND_CHAR;
          tok.ch   = item_byte;
        end
      end else begin
        outside = 1'b1;
      end

      // byte handling outside quotes
      if (outside) begin
        if (item_byte == csvt_pkg::CH_QUOTE) begin
          st_nxt.inside_quotes = 1'b1;
          st_nxt.field_begun   = 1'b1;
        end else if (item_byte == csvt_pkg::CH_COMMA) begin
          st_nxt.field_begun       = 1'b0;
          st_nxt.field_has_chars   = 1'b0;
          st_nxt.record_has_fields = 1'b1;
          tok.vld  = 1'b1;
          tok.kind = csvt_pkg::KIND_FIELD;
        end else if (item_byte == csvt_pkg::CH_LF || item_byte == csvt_pkg::CH_CR) begin
          if (item_byte == csvt_pkg::CH_CR) begin
            st_nxt.skip_linefeed = 1'b1;
          end
          if (rec_open) begin
            st_nxt.field_begun       = 1'b0;
            st_nxt.field_has_chars   = 1'b0;
            st_nxt.record_has_fields = 1'b0;
            tok.vld  = 1'b1;
            tok.kind = csvt_pkg::KIND_RECORD;
          end
        end else begin
          st_nxt.field_begun     = 1'b1;
          st_nxt.field_has_chars = 1'b1;
          tok.vld  = 1'b1;
          tok.kind = csvt_pkg::KIND_CHAR;
          tok.ch   = item_byte;
        end
      end
    end
    // nothing to process means no token
    if (!item_vld) begin
      tok.vld = 1'b0;
    end
  end

  // state register, updated when the held item is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/csvt_out_reg.sv
`default_nettype none
module csvt_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  csvt_pkg::csvt_tok_t    tok,
  output logic                   free,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic [1:0]             out_tuser
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] ch_r;
  logic [1:0] kind_r;

  // slot can take a token when empty or draining this cycle
  assign free    = !vld_r || out_tready;
  assign vld_nxt = load || (vld_r && !out_tready);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      ch_r   <= tok.ch;
      kind_r <= tok.kind;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = ch_r;
  assign out_tuser  = kind_r;

endmodule
`default_nettype wire

>>> src/csv_field_tokenizer_core.sv
// csv field tokenizer: splits csv text into field characters and field and
// record end marks (quoted fields, doubled quotes, cr / lf / crlf endings).
// input channel in_*: in_tdata is one text byte, in_tuser[0] is the command
// (0 text byte, 1 end of text, which flushes an open record and resets the
// parser state).
// result channel out_*: out_tdata is the character (zero for marks),
// out_tuser is the token kind (0 char, 1 end of field, 2 end of record).
// each input transaction gives zero or one result transaction.
// out_tvalid is registered: an item passes the input register, then the
// result register, before its result transaction.
// throughput: one transaction per cycle while the receiver does not stall,
// set by the combinational decision logic between the input register and
// the result register.
// when the receiver stalls the result register holds, and the input
// register keeps taking an item only if the held item gives no result or
// the result register is empty; otherwise in_tready falls.
// reset (rst_n low, synchronous) empties both registers and clears all
// parser state.
`default_nettype none
module csv_field_tokenizer_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] byte_value
  input  wire logic [0:0] in_tuser,   // [0] command
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] char_value
  output logic [1:0]      out_tuser   // [1:0] token_kind
);

  logic                s1_vld_r;
  logic                s1_cmd_r;
  logic [7:0]          s1_byte_r;
  logic                consume;
  logic                out_free;
  csvt_pkg::csvt_tok_t tok;

  // held item leaves when it gives nothing or the result slot has room
  assign consume   = s1_vld_r && (!tok.vld || out_free);
  assign in_tready = !s1_vld_r || consume;

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser[0];
      s1_byte_r <= in_tdata;
    end
  end

  // parser state and decision logic
  csvt_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (s1_vld_r),
    .item_cmd  (s1_cmd_r),
    .item_byte (s1_byte_r),
    .advance   (consume),
    .tok       (tok)
  );

  // result register
  csvt_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume && tok.vld),
    .tok        (tok),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
